// ===== rtl/srrip_pkg.sv =====
// Shared constants, types and codes of the SRRIP replacement unit.
`default_nettype none
package srrip_pkg;

  localparam int NUM_SETS = 8192;
  localparam int NUM_WAYS = 16;
  localparam int MAX_RRPV = 3;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int RRPV_W = $clog2(MAX_RRPV + 2);

  // fixed field widths of the request and response
  localparam int SET_IDX_W = 13;
  localparam int WAY_IDX_W = 4;
  localparam int ACC_W     = 3;
  localparam int CYC_W     = 5;
  localparam int VICTIM_W  = 4;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [RRPV_W-1:0] RRPV_HIT = '0;
  localparam logic [RRPV_W-1:0] RRPV_INS = RRPV_W'(MAX_RRPV - 1);
  localparam logic [RRPV_W-1:0] RRPV_MAX = RRPV_W'(MAX_RRPV);
  localparam logic [RRPV_W-1:0] RRPV_BYP = RRPV_W'(MAX_RRPV + 1);

  typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv_row_t;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [ACC_W-1:0] {
    ACC_LOAD      = 3'd0,
    ACC_RFO       = 3'd1,
    ACC_PREFETCH  = 3'd2,
    ACC_WRITEBACK = 3'd3,
    ACC_OTHER     = 3'd4
  } access_e;

  typedef enum logic {
    REG_BYPASS_EN = 1'b0
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              done;
    logic              byp_found;
    logic [WAY_W-1:0]  byp_way;
    logic [RRPV_W-1:0] top;
    logic [WAY_W-1:0]  top_way;
  } scan_res_t;

endpackage
`default_nettype wire

// ===== rtl/srrip_if.sv =====
// Request and response channel interfaces of the SRRIP replacement unit.
`default_nettype none
interface srrip_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [srrip_pkg::SET_IDX_W-1:0]  set_index;
  logic [srrip_pkg::WAY_IDX_W-1:0]  way_index;
  logic                             hit;
  logic [srrip_pkg::ACC_W-1:0]      access_type;
  logic                             set_full;
  logic                             bloom_hit;
  logic [srrip_pkg::CYC_W-1:0]      cycle_low;

  modport source (
    output valid, op, set_index, way_index, hit, access_type, set_full, bloom_hit, cycle_low,
    input  ready
  );
  modport sink (
    input  valid, op, set_index, way_index, hit, access_type, set_full, bloom_hit, cycle_low,
    output ready
  );
endinterface

interface srrip_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [srrip_pkg::VICTIM_W-1:0]  victim_way;
  logic                            bypassed;

  modport source (
    output valid, victim_way, bypassed,
    input  ready
  );
  modport sink (
    input  valid, victim_way, bypassed,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/srrip_scan.sv =====
// Serial way scanner: one compare per cycle over a set row.
`default_nettype none
module srrip_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  srrip_pkg::rrpv_row_t  row_i,
  output srrip_pkg::scan_res_t  res_o
);

  localparam logic [srrip_pkg::WAY_W-1:0] WayLast = srrip_pkg::WAY_W'(srrip_pkg::NUM_WAYS - 1);

  logic                           active_q;
  logic                           done_q;
  logic [srrip_pkg::WAY_W-1:0]    cnt_q;
  logic                           byp_found_q;
  logic [srrip_pkg::WAY_W-1:0]    byp_way_q;
  logic [srrip_pkg::RRPV_W-1:0]   top_q;
  logic [srrip_pkg::WAY_W-1:0]    top_way_q;
  logic [srrip_pkg::RRPV_W-1:0]   val;

  assign val = row_i[cnt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == WayLast) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // strict greater keeps the first way holding the largest value
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      byp_found_q <= 1'b0;
      byp_way_q   <= '0;
      top_q       <= '0;
      top_way_q   <= '0;
    end else if (active_q) begin
      if (val == srrip_pkg::RRPV_BYP && !byp_found_q) begin
        byp_found_q <= 1'b1;
        byp_way_q   <= cnt_q;
      end
      if (val > top_q) begin
        top_q     <= val;
        top_way_q <= cnt_q;
      end
    end
  end

  assign res_o.done      = done_q;
  assign res_o.byp_found = byp_found_q;
  assign res_o.byp_way   = byp_way_q;
  assign res_o.top       = top_q;
  assign res_o.top_way   = top_way_q;

endmodule
`default_nettype wire

// ===== rtl/srrip_replacement_with_bypass_unit.sv =====
// Top level: SRRIP replacement state with bypass marking, APB config, row memory.
// Victim query: row read, serial way scan, row write if the row is aged, then the output register.
//   Update: one row read and, except for writebacks, one row write.
// One request at a time; the next is taken once the result sits in the output register.
// After reset a clearing pass writes every set row to the maximum value, one row per
//   cycle (NUM_SETS = 8192 rows); requests wait, config writes are taken.
`default_nettype none
module srrip_replacement_with_bypass_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srrip_pkg::PADDR_W-1:0]   paddr,
  input  logic [srrip_pkg::PDATA_W-1:0]   pwdata,
  output logic [srrip_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  srrip_req_if.sink                       req_i,
  srrip_rsp_if.source                     rsp_o
);

  localparam logic [srrip_pkg::SET_W-1:0] SetLast = srrip_pkg::SET_W'(srrip_pkg::NUM_SETS - 1);

  srrip_pkg::state_e state_q, state_d;

  srrip_pkg::rrpv_row_t rrpv_mem [srrip_pkg::NUM_SETS];
  srrip_pkg::rrpv_row_t row_q;
  srrip_pkg::rrpv_row_t mem_wdata;
  srrip_pkg::rrpv_row_t upd_row;
  srrip_pkg::rrpv_row_t aged_row;
  srrip_pkg::rrpv_row_t clr_row;
  logic                          mem_we;
  logic                          mem_re;
  logic [srrip_pkg::SET_W-1:0]   mem_waddr;
  logic [srrip_pkg::SET_W-1:0]   clr_q;

  logic                              bypass_en_q;
  logic                              op_q;
  logic [srrip_pkg::SET_W-1:0]       set_q;
  logic [srrip_pkg::WAY_IDX_W-1:0]   way_q;
  logic                              hit_q;
  logic [srrip_pkg::ACC_W-1:0]       acc_q;
  logic                              full_q;
  logic                              bloom_q;
  logic [srrip_pkg::CYC_W-1:0]       cyc_q;

  logic                              out_valid_q;
  logic [srrip_pkg::VICTIM_W-1:0]    out_way_q;
  logic                              out_byp_q;
  logic                              out_load;
  logic [srrip_pkg::VICTIM_W-1:0]    rslt_way;
  logic                              rslt_byp;

  logic                              accept;
  logic                              scan_start;
  srrip_pkg::scan_res_t              scan_res;
  logic                              need_age;
  logic                              byp_cond;
  logic                              upd_write;
  logic [srrip_pkg::RRPV_W-1:0]      upd_val;
  logic [srrip_pkg::RRPV_W-1:0]      age_delta;
  logic                              cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == srrip_pkg::REG_BYPASS_EN);
  assign prdata = (paddr[2] == srrip_pkg::REG_BYPASS_EN) ?
                  {{(srrip_pkg::PDATA_W-1){1'b0}}, bypass_en_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_en_q <= 1'b0;
    end else if (cfg_wr) begin
      bypass_en_q <= pwdata[0];
    end
  end

  srrip_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .row_i   (row_q),
    .res_o   (scan_res)
  );

  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.op;
      set_q   <= srrip_pkg::SET_W'(req_i.set_index);
      way_q   <= req_i.way_index;
      hit_q   <= req_i.hit;
      acc_q   <= req_i.access_type;
      full_q  <= req_i.set_full;
      bloom_q <= req_i.bloom_hit;
      cyc_q   <= req_i.cycle_low;
    end
  end

  // update path
  assign byp_cond = bypass_en_q && !hit_q && full_q && !bloom_q && (cyc_q != '0) &&
                    (acc_q == srrip_pkg::ACC_LOAD || acc_q == srrip_pkg::ACC_RFO ||
                     acc_q == srrip_pkg::ACC_PREFETCH);
  assign upd_write = (acc_q != srrip_pkg::ACC_WRITEBACK) &&
                     (32'(way_q) < srrip_pkg::NUM_WAYS);
  assign upd_val = byp_cond ? srrip_pkg::RRPV_BYP :
                   (hit_q ? srrip_pkg::RRPV_HIT : srrip_pkg::RRPV_INS);

  always_comb begin
    upd_row = row_q;
    upd_row[srrip_pkg::WAY_W'(way_q)] = upd_val;
  end

  // ageing: all ways move up by the distance of the oldest way to the maximum
  assign need_age  = !scan_res.byp_found && (scan_res.top != srrip_pkg::RRPV_MAX);
  assign age_delta = srrip_pkg::RRPV_MAX - scan_res.top;

  always_comb begin
    for (int w = 0; w < srrip_pkg::NUM_WAYS; w++) begin
      aged_row[w] = row_q[w] + age_delta;
      clr_row[w]  = srrip_pkg::RRPV_MAX;
    end
  end

  always_comb begin
    if (op_q == srrip_pkg::OP_VICTIM) begin
      rslt_way = srrip_pkg::VICTIM_W'(scan_res.byp_found ? scan_res.byp_way : scan_res.top_way);
      rslt_byp = scan_res.byp_found;
    end else begin
      rslt_way = '0;
      rslt_byp = upd_write && byp_cond;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srrip_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == srrip_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = upd_row;
    scan_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      srrip_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = clr_row;
        if (clr_q == SetLast) begin
          state_d = srrip_pkg::ST_IDLE;
        end
      end
      srrip_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = srrip_pkg::ST_READ;
        end
      end
      srrip_pkg::ST_READ: begin
        mem_re = 1'b1;
        if (op_q == srrip_pkg::OP_VICTIM) begin
          scan_start = 1'b1;
          state_d    = srrip_pkg::ST_SCAN;
        end else begin
          state_d = srrip_pkg::ST_WRITE;
        end
      end
      srrip_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          state_d = need_age ? srrip_pkg::ST_WRITE : srrip_pkg::ST_DONE;
        end
      end
      srrip_pkg::ST_WRITE: begin
        if (op_q == srrip_pkg::OP_VICTIM) begin
          mem_we    = 1'b1;
          mem_wdata = aged_row;
        end else begin
          mem_we = upd_write;
        end
        state_d = srrip_pkg::ST_DONE;
      end
      srrip_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = srrip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srrip_pkg::ST_IDLE;
      end
    endcase
  end

  // row memory, single port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rrpv_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      row_q <= rrpv_mem[set_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_way_q <= rslt_way;
      out_byp_q <= rslt_byp;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.victim_way = out_way_q;
  assign rsp_o.bypassed   = out_byp_q;

endmodule
`default_nettype wire
